@@ rtl/bpssm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpssm_pkg
// Types, constants and helper functions shared by the skip string matcher.
// ----------------------------------------------------------------------------
package bpssm_pkg;

   localparam int MAX_PATTERN = 30;
   localparam int LEN_W       = 5;
   localparam int WIN_DEPTH   = 32;
   localparam int WIN_AW      = $clog2(WIN_DEPTH);
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int POS_W       = 32;
   localparam int PAT_BITS    = MAX_PATTERN * 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LENGTH   = 3'd0,
      CSR_BYTES_0  = 3'd1,
      CSR_BYTES_8  = 3'd2,
      CSR_BYTES_16 = 3'd3,
      CSR_BYTES_24 = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_SHIFT
   } eng_state_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       first_of_text;
      logic       last_of_text;
   } req_type;

   typedef struct packed {
      logic [31:0] match_start;
      logic [31:0] match_total;
   } rsp_type;

   typedef logic [MAX_PATTERN-1:0] vec_type;
   typedef logic [MAX_PATTERN-1:0][7:0] pat_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] r;
      r = len;
      if (len == '0) r = LEN_W'(1);
      if (len > LEN_W'(MAX_PATTERN)) r = LEN_W'(MAX_PATTERN);
      return r;
   endfunction

   function automatic vec_type len_mask(input logic [LEN_W-1:0] m);
      vec_type r;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         r[k] = (LEN_W'(k) < m);
      end
      return r;
   endfunction

   function automatic vec_type char_mask(input logic [7:0] c, input pat_type pat,
                                         input logic [LEN_W-1:0] m);
      vec_type r;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         r[k] = (LEN_W'(k) < m) && (pat[k] != c);
      end
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] high_bit(input vec_type v);
      logic [LEN_W-1:0] r;
      r = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (v[k]) r = LEN_W'(k);
      end
      return r;
   endfunction

endpackage

@@ rtl/bpssm_queue.sv @@
// ----------------------------------------------------------------------------
// bpssm_queue
// Front end: takes input transfers into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module bpssm_queue
   import bpssm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    q_valid,
   output req_type q_data,
   input  logic    q_pop
);

   req_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

@@ rtl/bpssm_engine.sv @@
// ----------------------------------------------------------------------------
// bpssm_engine
// Back end: buffers text bytes and checks windows backwards with D and b.
// ----------------------------------------------------------------------------
module bpssm_engine
   import bpssm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  req_type          q_data,
   output logic             q_pop,
   input  logic [LEN_W-1:0] cfg_len,
   input  pat_type          cfg_pat,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   eng_state_type    state_ff, state_in;
   logic [LEN_W-1:0] m_ff, m_in;
   pat_type          pat_ff, pat_in;
   vec_type          d_ff, d_in;
   vec_type          b_ff, b_in;
   logic [POS_W-1:0] we_ff, we_in;
   logic [POS_W-1:0] br_ff, br_in;
   logic [POS_W-1:0] fc_ff, fc_in;
   logic [WIN_AW-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0] dist_ff, dist_in;
   logic [7:0]       rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [7:0]       win_mem [WIN_DEPTH];

   logic              wr_en;
   logic [WIN_AW-1:0] rd_addr;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_addr   = slot_ff - WIN_AW'(dist_ff);

   always_comb begin
      logic [LEN_W-1:0]  m_new;
      vec_type           mask;
      vec_type           top;
      vec_type           t;
      vec_type           d_new;
      vec_type           b_new;
      logic [LEN_W-1:0]  delta;
      logic              rsp_free;
      logic [POS_W-1:0]  fc_inc;
      logic [POS_W-1:0]  we_tmp;
      logic [POS_W-1:0]  br_tmp;

      state_in = state_ff;
      m_in     = m_ff;
      pat_in   = pat_ff;
      d_in     = d_ff;
      b_in     = b_ff;
      we_in    = we_ff;
      br_in    = br_ff;
      fc_in    = fc_ff;
      slot_in  = slot_ff;
      dist_in  = dist_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;

      rsp_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      mask   = len_mask(m_ff);
      top    = vec_type'(1) << (m_ff - LEN_W'(1));
      m_new  = clamp_len(cfg_len);
      t      = char_mask(rd_data_ff, pat_ff, m_ff);
      d_new  = (d_ff | (t << dist_ff)) & mask;
      b_new  = b_ff & ~(top >> dist_ff);
      fc_inc = (fc_ff == '1) ? fc_ff : fc_ff + POS_W'(1);
      delta  = m_ff - LEN_W'(1) - high_bit(~d_ff & mask);
      we_tmp = we_ff;
      br_tmp = br_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && rsp_free) begin
               q_pop = 1'b1;
               wr_en = 1'b1;
               if (q_data.first_of_text) begin
                  m_in    = m_new;
                  pat_in  = cfg_pat;
                  d_in    = '0;
                  b_in    = len_mask(m_new);
                  we_tmp  = POS_W'(m_new) - POS_W'(1);
                  br_tmp  = '0;
                  fc_in   = '0;
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + WIN_AW'(1);
               end
               we_in = we_tmp;
               br_in = br_tmp + POS_W'(1);
               if (we_tmp == br_tmp) begin
                  dist_in  = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            d_in = d_new;
            b_in = b_new;
            state_in = ST_SHIFT;
            if ((d_new & top) == '0) begin
               if (b_new == '0) begin
                  d_in         = d_new | top;
                  fc_in        = fc_inc;
                  rsp_valid_in = 1'b1;
                  rsp_data_in.match_start = we_ff - POS_W'(m_ff) + POS_W'(1);
                  rsp_data_in.match_total = fc_inc;
               end else begin
                  dist_in  = m_ff - LEN_W'(1) - high_bit(b_new);
                  state_in = ST_READ;
               end
            end
         end
         ST_SHIFT: begin
            state_in = ST_IDLE;
            if (d_ff == mask) begin
               d_in  = '0;
               b_in  = mask;
               we_in = we_ff + POS_W'(m_ff);
            end else begin
               d_in  = (d_ff << delta) & mask;
               b_in  = ((b_ff | ~mask) >> delta) & mask;
               we_in = we_ff + POS_W'(delta);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         m_ff         <= LEN_W'(1);
         pat_ff       <= '0;
         d_ff         <= '0;
         b_ff         <= vec_type'(1);
         we_ff        <= '0;
         br_ff        <= '0;
         fc_ff        <= '0;
         slot_ff      <= '0;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         m_ff         <= m_in;
         pat_ff       <= pat_in;
         d_ff         <= d_in;
         b_ff         <= b_in;
         we_ff        <= we_in;
         br_ff        <= br_in;
         fc_ff        <= fc_in;
         slot_ff      <= slot_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rd_data_ff  <= win_mem[rd_addr];
      if (wr_en) begin
         win_mem[slot_in] <= q_data.text_byte;
      end
   end

endmodule

@@ rtl/bit_parallel_skip_string_matcher.sv @@
// ----------------------------------------------------------------------------
// bit_parallel_skip_string_matcher
// Exact single-pattern matcher with bit-parallel backward window checks.
//
//   Channel   Ports                          Moves
//   input     req_valid req_stall req_data   one text byte per transfer
//   result    rsp_valid rsp_stall rsp_data   one occurrence per transfer
//   config    csr_we csr_index csr_wdata     pattern length and bytes
//
// A byte that closes no window is taken in ST_IDLE alone; one that closes a
// window adds a window memory read (ST_READ) and compare (ST_EVAL) per byte
// examined, then ST_SHIFT. A two-entry queue takes transfers while the engine
// works. Reset is synchronous and starts a text with a one-byte zero pattern.
// A stalled result holds the engine before its next byte, never the queue.
// ----------------------------------------------------------------------------
module bit_parallel_skip_string_matcher
   import bpssm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LEN_W-1:0]    len_ff, len_in;
   logic [PAT_BITS-1:0] pat_ff, pat_in;
   logic                q_valid;
   req_type             q_data;
   logic                q_pop;

   always_comb begin
      len_in = len_ff;
      pat_in = pat_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LENGTH:   len_in = csr_wdata[LEN_W-1:0];
            CSR_BYTES_0:  pat_in[63:0] = csr_wdata;
            CSR_BYTES_8:  pat_in[127:64] = csr_wdata;
            CSR_BYTES_16: pat_in[191:128] = csr_wdata;
            CSR_BYTES_24: pat_in[239:192] = csr_wdata[47:0];
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
         pat_ff <= '0;
      end else begin
         len_ff <= len_in;
         pat_ff <= pat_in;
      end
   end

   bpssm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   bpssm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .cfg_len   (len_ff),
      .cfg_pat   (pat_type'(pat_ff)),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ verif/bit_parallel_skip_string_matcher_checker.sv @@
// ----------------------------------------------------------------------------
// bit_parallel_skip_string_matcher_checker
// Watches the text, result and register ports of the skip string matcher,
// predicts every found occurrence from its own copy of the pattern table,
// window and search vectors, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module bit_parallel_skip_string_matcher_checker
   import bpssm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    pending
);

   logic [4:0]  cfg_len;
   logic [63:0] cfg_pat [4];
   logic [31:0] char_table [256];
   logic [7:0]  text_buf [32];
   logic [31:0] found_vec;
   logic [31:0] open_vec;
   logic [31:0] window_end;
   logic [31:0] byte_count;
   logic [31:0] occurrences;
   int unsigned m_len;
   logic [4:0]  newest;
   rsp_type     occurrence_q [$];

   function automatic int unsigned top_one(input logic [31:0] v);
      int unsigned r;
      r = 0;
      for (int k = 0; k < 32; k++) begin
         if (v[k]) r = k;
      end
      return r;
   endfunction

   function automatic logic [31:0] lmask();
      return (32'd1 << m_len) - 32'd1;
   endfunction

   task automatic begin_text();
      logic [7:0] c;
      m_len = (cfg_len == 0) ? 1 : ((cfg_len > MAX_PATTERN) ? MAX_PATTERN : cfg_len);
      for (int k = 0; k < 256; k++) char_table[k] = lmask();
      for (int k = 0; k < m_len; k++) begin
         c = cfg_pat[k / 8][8 * (k % 8) +: 8];
         char_table[c][k] = 1'b0;
      end
      found_vec = '0;
      open_vec = lmask();
      window_end = m_len - 1;
      byte_count = '0;
      occurrences = '0;
   endtask

   task automatic search_byte(input req_type item);
      logic [31:0] mk, topb, t, pos, j, span, d;
      logic [4:0]  rd;
      if (item.first_of_text) begin
         begin_text();
         newest = 5'd31;
      end
      newest = newest + 5'd1;
      text_buf[newest] = item.text_byte;
      pos = byte_count;
      byte_count = byte_count + 1;
      mk = lmask();
      topb = 32'd1 << (m_len - 1);
      j = window_end;
      while (window_end == pos) begin
         span = window_end - j;
         rd = newest - 5'(pos - j);
         t = char_table[text_buf[rd]];
         found_vec = (found_vec | (t << span)) & mk;
         open_vec[m_len - 1 - span] = 1'b0;
         if ((found_vec & topb) == 0) begin
            if (open_vec == 0) begin
               found_vec = found_vec | topb;
               if (occurrences != 32'hFFFF_FFFF) occurrences = occurrences + 1;
               occurrence_q.push_back(rsp_type'{match_start: window_end - m_len + 1,
                                                match_total: occurrences});
            end else begin
               j = window_end - (m_len - top_one(open_vec) - 1);
               continue;
            end
         end
         if (found_vec == mk) begin
            found_vec = '0;
            open_vec = mk;
            window_end = window_end + m_len;
         end else begin
            d = m_len - top_one(~found_vec & mk) - 1;
            found_vec = (found_vec << d) & mk;
            open_vec = ((open_vec | ~mk) >> d) & mk;
            window_end = window_end + d;
         end
         j = window_end;
      end
   endtask

   assign pending = occurrence_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_len = 5'd1;
         for (int k = 0; k < 4; k++) cfg_pat[k] = '0;
         for (int k = 0; k < 32; k++) text_buf[k] = '0;
         newest = '0;
         begin_text();
         occurrence_q.delete();
         failures = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LENGTH:   cfg_len = csr_wdata[4:0];
               CSR_BYTES_0:  cfg_pat[0] = csr_wdata;
               CSR_BYTES_8:  cfg_pat[1] = csr_wdata;
               CSR_BYTES_16: cfg_pat[2] = csr_wdata;
               CSR_BYTES_24: cfg_pat[3] = {16'h0, csr_wdata[47:0]};
               default: ;
            endcase
         end
         if (req_valid && !req_stall) search_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (occurrence_q.size() == 0) begin
               failures = failures + 1;
               if (failures <= 10)
                  $display("ERROR: unexpected result transfer start=%0d total=%0d",
                           rsp_data.match_start, rsp_data.match_total);
            end else begin
               want = occurrence_q.pop_front();
               if (want !== rsp_data) begin
                  failures = failures + 1;
                  if (failures <= 10)
                     $display("ERROR: expected start=%0d total=%0d, got start=%0d total=%0d",
                              want.match_start, want.match_total,
                              rsp_data.match_start, rsp_data.match_total);
               end
            end
         end
      end
   end

endmodule

@@ verif/bit_parallel_skip_string_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// bit_parallel_skip_string_matcher_tb
// Drives texts into the skip string matcher under changing patterns: a short
// directed part on the length limits and text boundaries, then random texts
// built from planted pattern copies over small alphabets, with random idling
// on both channels. A checker module predicts and compares the results.
// ----------------------------------------------------------------------------
module bit_parallel_skip_string_matcher_tb;
   import bpssm_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LENGTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    failures;
   int                    pending;
   int                    send_idle_pct = 17;
   int                    rsp_stall_pct = 81;
   int                    sent = 0;
   logic [7:0]            pat [30];
   logic [7:0]            alpha [4];
   int unsigned           eff_len;
   int unsigned           n_alpha;

   always #6 clock = ~clock;

   bit_parallel_skip_string_matcher dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   bit_parallel_skip_string_matcher_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .failures, .pending
   );

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

   task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req_type'{text_byte: b, first_of_text: first, last_of_text: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (sent < 283) begin
         send_idle_pct = 17;
         rsp_stall_pct = 81;
      end else if (sent < 566) begin
         send_idle_pct = 81;
         rsp_stall_pct = 17;
      end else begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Loads pat[] as the pattern, with the given raw length register value.
   task automatic load_pattern(input logic [4:0] len_raw);
      logic [63:0] words [4];
      for (int w = 0; w < 4; w++) words[w] = {$urandom, $urandom};
      for (int k = 0; k < 30; k++) words[k / 8][8 * (k % 8) +: 8] = pat[k];
      write_reg(CSR_LENGTH, {$urandom, 27'($urandom), len_raw});
      write_reg(CSR_BYTES_0, words[0]);
      write_reg(CSR_BYTES_8, words[1]);
      write_reg(CSR_BYTES_16, words[2]);
      write_reg(CSR_BYTES_24, words[3]);
      eff_len = (len_raw == 0) ? 1 : ((len_raw > 30) ? 30 : len_raw);
   endtask

   task automatic send_text(input int unsigned n, input bit fresh);
      logic [7:0] b;
      int unsigned i;
      int unsigned copy_at;
      i = 0;
      copy_at = 0;
      while (i < n) begin
         if (copy_at == 0 && $urandom_range(99) < 45) copy_at = eff_len;
         if (copy_at != 0) begin
            b = pat[eff_len - copy_at];
            copy_at--;
         end else if ($urandom_range(99) < 10) begin
            b = 8'($urandom_range(255));
         end else begin
            b = alpha[$urandom_range(n_alpha - 1)];
         end
         send_byte(b, fresh && i == 0, i == n - 1);
         i++;
      end
   endtask

   initial begin
      logic [4:0] len_raw;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      wait_quiet();

      for (int k = 0; k < 30; k++) pat[k] = 8'(k * 37 + 5);
      load_pattern(5'd31);
      for (int k = 0; k < 30; k++) send_byte(pat[k], k == 0, 1'b0);
      send_byte(8'hAA, 1'b0, 1'b1);
      wait_quiet();
      pat[0] = 8'hFF;
      load_pattern(5'd0);
      send_byte(8'h12, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      wait_quiet();

      while (sent < 850) begin
         len_raw = ($urandom_range(99) < 70) ? 5'($urandom_range(1, 6))
                                             : 5'($urandom_range(0, 31));
         n_alpha = $urandom_range(2, 4);
         for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(255));
         for (int k = 0; k < 30; k++) pat[k] = alpha[$urandom_range(n_alpha - 1)];
         load_pattern(len_raw);
         repeat ($urandom_range(1, 3)) begin
            send_text($urandom_range(8, 3 * eff_len + 20), $urandom_range(99) < 90);
         end
         wait_quiet();
      end

      wait_quiet();
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(12 * 3000000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bpssm_pkg.sv
rtl/bpssm_queue.sv
rtl/bpssm_engine.sv
rtl/bit_parallel_skip_string_matcher.sv
verif/bit_parallel_skip_string_matcher_checker.sv
verif/bit_parallel_skip_string_matcher_tb.sv
